>>> rtl/button_debounce_press_classifier_core_macros.svh
// Assertion shorthands used by the checker file.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_CORE_MACROS_SVH

// Checked on every rising edge outside reset.
`define BDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BDPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bdpc_pkg.sv
`default_nettype none
package bdpc_pkg;

  localparam int BDPC_TIME_BITS_DEF = 16;

  localparam int EV_W     = 2;
  localparam int LONG_W   = 16;
  localparam int DEB_W    = 8;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic [EV_W-1:0] event_t;

  localparam event_t EV_NONE  = 2'd0;
  localparam event_t EV_SHORT = 2'd1;
  localparam event_t EV_LONG  = 2'd2;

  // Register index, taken from paddr[3:2].
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ENABLED  = 2'd0;
  localparam reg_idx_t REG_LONG_MS  = 2'd1;
  localparam reg_idx_t REG_DEBOUNCE = 2'd2;

  localparam logic              ENABLED_RST  = 1'b1;
  localparam logic [LONG_W-1:0] LONG_MS_RST  = 16'd1000;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd50;

  typedef struct packed {
    logic              enabled;
    logic [LONG_W-1:0] long_press_ms;
    logic [DEB_W-1:0]  debounce_ms;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/bdpc_cfg_regs.sv
`default_nettype none
module bdpc_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bdpc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [bdpc_pkg::DATA_W-1:0] pwdata,
  output logic      [bdpc_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output bdpc_pkg::cfg_t                   cfg
);
  import bdpc_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLED:  cfg_nxt.enabled       = pwdata[0];
        REG_LONG_MS:  cfg_nxt.long_press_ms = pwdata[LONG_W-1:0];
        REG_DEBOUNCE: cfg_nxt.debounce_ms   = pwdata[DEB_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLED:  prdata = {{(DATA_W-1){1'b0}}, cfg_r.enabled};
      REG_LONG_MS:  prdata = {{(DATA_W-LONG_W){1'b0}}, cfg_r.long_press_ms};
      REG_DEBOUNCE: prdata = {{(DATA_W-DEB_W){1'b0}}, cfg_r.debounce_ms};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled       <= ENABLED_RST;
      cfg_r.long_press_ms <= LONG_MS_RST;
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bdpc_tracker.sv
`default_nettype none
module bdpc_tracker #(
  parameter int TIME_BITS = bdpc_pkg::BDPC_TIME_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bdpc_pkg::cfg_t cfg,
  input  wire logic           tick,
  input  wire logic           pin_level,
  input  wire logic           take_event,
  output bdpc_pkg::event_t    result
);
  import bdpc_pkg::*;

  localparam int CMP_W = (TIME_BITS > LONG_W) ? TIME_BITS : LONG_W;
  localparam logic [TIME_BITS-1:0] HELD_MAX = {TIME_BITS{1'b1}};

  logic                 last_level_r, last_level_nxt;
  logic                 armed_r,      armed_nxt;
  logic [TIME_BITS-1:0] held_r,       held_nxt;
  logic [DEB_W-1:0]     ignore_r,     ignore_nxt;
  event_t               latched_r,    latched_nxt;

  logic [TIME_BITS-1:0] held_inc;
  logic                 is_long;
  event_t               ev_upd;

  // Held time counts every enabled tick while armed, saturating.
  assign held_inc = (armed_r && (held_r != HELD_MAX)) ?
                    held_r + {{(TIME_BITS-1){1'b0}}, 1'b1} : held_r;
  assign is_long  = (cfg.long_press_ms != '0) &&
                    (CMP_W'(held_inc) > CMP_W'(cfg.long_press_ms));

  always_comb begin
    last_level_nxt = last_level_r;
    armed_nxt      = armed_r;
    held_nxt       = held_r;
    ignore_nxt     = ignore_r;
    ev_upd         = latched_r;
    latched_nxt    = latched_r;
    result         = EV_NONE;
    if (tick && cfg.enabled) begin
      held_nxt = held_inc;
      if (ignore_r != '0) begin
        // Inside the window: skip sampling.
        ignore_nxt = ignore_r - 1'b1;
      end else begin
        if (!pin_level && !last_level_r) begin
          if (armed_r && is_long) begin
            ev_upd    = EV_LONG;
            armed_nxt = 1'b0;
          end
        end else if (!pin_level && last_level_r) begin
          armed_nxt  = 1'b1;
          held_nxt   = '0;
          ignore_nxt = (cfg.debounce_ms == '0) ? '0 : cfg.debounce_ms - 1'b1;
        end else if (pin_level && !last_level_r) begin
          if (armed_r) begin
            ev_upd = is_long ? EV_LONG : EV_SHORT;
          end
          armed_nxt = 1'b0;
        end
        last_level_nxt = pin_level;
      end
      latched_nxt = ev_upd;
      if (take_event) begin
        result      = ev_upd;
        latched_nxt = EV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b1;
      armed_r      <= 1'b0;
      held_r       <= '0;
      ignore_r     <= '0;
      latched_r    <= EV_NONE;
    end else begin
      last_level_r <= last_level_nxt;
      armed_r      <= armed_nxt;
      held_r       <= held_nxt;
      ignore_r     <= ignore_nxt;
      latched_r    <= latched_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bdpc_out_buf.sv
`default_nettype none
module bdpc_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bdpc_pkg::event_t push_data,
  output logic                  can_push,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bdpc_pkg::event_t      out_data
);
  import bdpc_pkg::*;

  logic   head_vld_r, head_vld_nxt;
  logic   skid_vld_r, skid_vld_nxt;
  event_t head_r,     head_nxt;
  event_t skid_r,     skid_nxt;
  logic   pop;

  assign pop       = head_vld_r & out_ready;
  assign can_push  = ~skid_vld_r;
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (!head_vld_r) begin
      if (push) begin
        head_vld_nxt = 1'b1;
        head_nxt     = push_data;
      end
    end else if (pop) begin
      if (skid_vld_r) begin
        // Advance the skid word; refill it if a new word arrives.
        head_nxt     = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = push_data;
      end else begin
        head_vld_nxt = push;
        head_nxt     = push_data;
      end
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/button_debounce_press_classifier_core.sv
// Channel  Direction  Handshake                     Word
// in       input      in_valid / in_ready           in_pin_level, in_take_event (one tick)
// out      output     out_valid / out_ready         out_press_event
// cfg      input      psel/penable/pwrite, pready   cfg_paddr, cfg_pwdata, cfg_prdata
//
// One input word is taken per cycle while in_ready is high; its result word is registered into the output buffer.
// Press state updates in the accept cycle, so the tracker sets no rate limit.
// A two-word output buffer (head plus skid) holds results; in_ready drops only
// when both are full, so a stalled consumer stops input after two words.
// Reset (rst_n low, synchronous) restores register defaults and clears state.
`default_nettype none
module button_debounce_press_classifier_core #(
  parameter int TIME_BITS = bdpc_pkg::BDPC_TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // tick input
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_pin_level,
  input  wire logic                        in_take_event,
  // event output
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [bdpc_pkg::EV_W-1:0]   out_press_event,
  // register port
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [bdpc_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [bdpc_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [bdpc_pkg::DATA_W-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import bdpc_pkg::*;

  cfg_t   cfg;
  logic   tick;
  event_t result;
  event_t buf_data;
  logic   can_push;

  // A tick counts only when its word is accepted.
  assign in_ready        = can_push;
  assign tick            = in_valid & can_push;
  assign out_press_event = buf_data;

  bdpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Debounce, held-time count and short/long latch.
  bdpc_tracker #(
    .TIME_BITS (TIME_BITS)
  ) u_trk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .tick       (tick),
    .pin_level  (in_pin_level),
    .take_event (in_take_event),
    .result     (result)
  );

  // Hold result words until the consumer takes them.
  bdpc_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (buf_data)
  );

endmodule
`default_nettype wire

>>> rtl/bdpc_checker.sv
`default_nettype none
`include "button_debounce_press_classifier_core_macros.svh"
module bdpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_press_event
);

  `BDPC_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "out_valid after reset")
  `BDPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_press_event), "stalled word changed")
  `BDPC_ASSERT(a_ev_code, out_valid |-> out_press_event != 2'd3, "illegal event code")
  `BDPC_ASSERT(a_full_has_out, !in_ready |-> out_valid, "input stalled with no word shown")
  `BDPC_ASSERT(a_accept_shows, in_valid && in_ready && !out_valid |=> out_valid, "accepted word not shown")

endmodule

bind button_debounce_press_classifier_core bdpc_checker u_bdpc_chk (.*);
`default_nettype wire

>>> tb/sv/button_debounce_press_classifier_core_test.sv
`timescale 1ns / 100ps

module button_debounce_press_classifier_core_test;
  import bdpc_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 12;
  localparam int HELD_W       = BDPC_TIME_BITS_DEF;
  // Longest correct quiet stretch is a long sender gap plus a long consumer
  // stall plus a register write; take that many times over.
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 300;

  // Clock, reset and every block input start at a known value.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic              in_pin_level  = 1'b1;
  logic              in_take_event = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b1;
  logic [EV_W-1:0]   out_press_event;
  logic              cfg_psel      = 1'b0;
  logic              cfg_penable   = 1'b0;
  logic              cfg_pwrite    = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr     = '0;
  logic [DATA_W-1:0] cfg_pwdata    = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // Shadow of the register file, updated when a write lands.
  logic              en_q   = ENABLED_RST;
  logic [LONG_W-1:0] long_q = LONG_MS_RST;
  logic [DEB_W-1:0]  deb_q  = DEBOUNCE_RST;

  // Shadow of the press tracker.
  logic              lvl_q     = 1'b1;
  logic              armed_q   = 1'b0;
  logic [HELD_W-1:0] held_q    = '0;
  logic [DEB_W-1:0]  ign_q     = '0;
  event_t            latched_q = EV_NONE;

  // Expected press_event words, oldest first.
  event_t      press_event_q[$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int unsigned ticks_sent     = 0;
  // Clear to run a stretch with neither side idling.
  logic        idle_on        = 1'b1;
  int          stall_left     = 0;

  button_debounce_press_classifier_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pin_level    (in_pin_level),
    .in_take_event   (in_take_event),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_press_event (out_press_event),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // A hold counts as long only once it strictly exceeds the threshold;
  // a zero threshold turns long presses off.
  function automatic logic held_long();
    return (long_q != '0) && (held_q > long_q);
  endfunction

  // Advance the shadow tracker by one tick and return the word it emits.
  function automatic event_t classify_tick(logic level, logic take);
    event_t word;
    word = EV_NONE;
    // Disabled: freeze everything, keep any latched event, read back none.
    if (en_q) begin
      // Held time runs on every armed tick, ignored ones too, and saturates.
      if (armed_q && held_q != '1) held_q = held_q + 1'b1;
      if (ign_q != '0) begin
        // Inside the window: skip sampling and keep the old level.
        ign_q = ign_q - 1'b1;
      end else begin
        if (!level && !lvl_q) begin
          if (armed_q && held_long()) begin
            latched_q = EV_LONG;
            armed_q   = 1'b0;
          end
        end else if (!level && lvl_q) begin
          armed_q = 1'b1;
          held_q  = '0;
          ign_q   = (deb_q == '0) ? '0 : deb_q - 1'b1;
        end else if (level && !lvl_q) begin
          // Release after a long already fired latches nothing: disarmed.
          if (armed_q) latched_q = held_long() ? EV_LONG : EV_SHORT;
          armed_q = 1'b0;
        end
        lvl_q = level;
      end
      // Read after the update, so a fresh event is returned and cleared.
      if (take) begin
        word      = latched_q;
        latched_q = EV_NONE;
      end
    end
    return word;
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // Mostly short gaps, a few long ones; none while idling is off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic rand_take();
    return ($urandom_range(0, 6) == 0);
  endfunction

  // Input and output monitor. Predict on each accepted tick, then check each
  // accepted result against the oldest expectation. Also run the watchdog.
  always @(posedge clk) begin
    event_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        press_event_q.push_back(classify_tick(in_pin_level, in_take_event));
      if (out_valid && out_ready) begin
        if (press_event_q.size() == 0) begin
          note_mismatch("press_event with nothing pending", DATA_W'(EV_NONE),
                        DATA_W'(out_press_event));
        end else begin
          want = press_event_q.pop_front();
          if (out_press_event !== want)
            note_mismatch("press_event", DATA_W'(want), DATA_W'(out_press_event));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Consumer side: drop ready for random stretches while idling is on.
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ready  = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready  = 1'b1;
      stall_left = pick_gap();
    end
  end

  // Send one tick word. Valid stays high after acceptance until the next
  // call replaces the payload or a gap drops it at the falling edge.
  task automatic send_tick(input logic level, input logic take);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_pin_level  = level;
    in_take_event = take;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Hold off the sender until every expected word has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (press_event_q.size() != 0) @(negedge clk);
  endtask

  // Write one register while idle, then read it back.
  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    wait_drained();
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ENABLED: begin
        en_q = value[0];
        mask = 32'h1;
      end
      REG_LONG_MS: begin
        long_q = value[LONG_W-1:0];
        mask   = 32'hFFFF;
      end
      REG_DEBOUNCE: begin
        deb_q = value[DEB_W-1:0];
        mask  = 32'hFF;
      end
      default: mask = '0;
    endcase
    // Read phase: setup, then access.
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if ((cfg_prdata & mask) !== (value & mask))
      note_mismatch("register readback", value & mask, cfg_prdata & mask);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic set_config(input logic en, input int unsigned long_ms,
                            input int unsigned deb_ms);
    cfg_write(REG_ENABLED, DATA_W'(en));
    cfg_write(REG_LONG_MS, DATA_W'(long_ms));
    cfg_write(REG_DEBOUNCE, DATA_W'(deb_ms));
  endtask

  // One press: rest released ticks, an edge, hold-1 more pressed ticks with
  // chatter on the first few, then a release that often reads at once.
  task automatic press_run(input int unsigned rest, input int unsigned hold,
                           input int unsigned bounce);
    for (int unsigned k = 0; k < rest; k++) send_tick(1'b1, rand_take());
    send_tick(1'b0, rand_take());
    for (int unsigned k = 1; k < hold; k++)
      send_tick((k <= bounce) ? 1'($urandom_range(0, 1)) : 1'b0, rand_take());
    send_tick(1'b1, 1'($urandom_range(0, 1)));
  endtask

  // Reset values in force: read with nothing latched, then a short press
  // past the 50-tick window.
  task automatic test_reset_settings();
    send_tick(1'b1, 1'b1);
    repeat (60) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  // Short press read on the release tick; long press firing while held,
  // release after it latching nothing, and a second read coming back empty.
  task automatic test_basic_events();
    set_config(1'b1, 4, 2);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    repeat (7) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
  endtask

  // Release inside the ignore window is seen once the window closes.
  task automatic test_debounce_window();
    cfg_write(REG_DEBOUNCE, 32'd3);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  // Zero threshold: any hold classifies as short.
  task automatic test_long_disabled();
    cfg_write(REG_LONG_MS, 32'd0);
    repeat (9) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  // Disabled block reads none and keeps the pending event for later.
  task automatic test_enable_freeze();
    cfg_write(REG_DEBOUNCE, 32'd1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    cfg_write(REG_ENABLED, 32'd0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    cfg_write(REG_ENABLED, 32'd1);
    send_tick(1'b1, 1'b1);
  endtask

  // Random phases: each picks settings (extremes included), then runs
  // mostly well-formed presses with random content, plus noise, presses
  // broken inside the window, and pauses for the pipeline to empty.
  task automatic test_random_phases();
    int unsigned start, long_v, deb_v, runs, hold_max;
    logic        en_v;
    start = ticks_sent;
    while (ticks_sent - start < RANDOM_ITEMS) begin
      en_v = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 5))
        0:       long_v = 0;
        1:       long_v = 1;
        2:       long_v = 65535;
        default: long_v = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 9))
        0:       deb_v = 255;
        1:       deb_v = 1;
        default: deb_v = $urandom_range(2, 6);
      endcase
      set_config(en_v, long_v, deb_v);
      idle_on  = ($urandom_range(0, 3) != 0);
      runs     = (deb_v == 255) ? 2 : $urandom_range(3, 8);
      hold_max = deb_v + ((long_v == 0 || long_v > 30) ? 30 : 2 * long_v + 4);
      repeat (runs) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(4, 12))
               send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          1: press_run($urandom_range(0, 3), $urandom_range(1, deb_v), deb_v);
          2: begin
            wait_drained();
            press_run($urandom_range(0, 4), $urandom_range(1, hold_max), 0);
          end
          default: press_run($urandom_range(0, 4), $urandom_range(1, hold_max),
                             $urandom_range(0, deb_v - 1));
        endcase
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_reset_settings();
    test_basic_events();
    test_debounce_window();
    test_long_disabled();
    test_enable_freeze();
    test_random_phases();

    // Drain, then let the output buffer settle before the verdict.
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (press_event_q.size() != 0)
      note_mismatch("words still pending", '0, DATA_W'(press_event_q.size()));
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
